FILE: hw/rtl/qmr_pkg.sv
// Package with the types, constants and helper functions of the quaternion unit.
`timescale 1ns / 1ps

package qmr_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [PAIR_W-1:0]    pair_t;
  typedef logic signed [SUM_W-1:0]     sum_t;

  // Element 0 is the real part, then i, j and k.
  typedef word_t [3:0] quat_t;

  localparam longint WMAX_L   = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam longint ONE_FULL = longint'(1) << FRAC_BITS;
  localparam longint ONE_SAT  = (ONE_FULL > WMAX_L) ? WMAX_L : ONE_FULL;

  localparam word_t ONE_Q     = ONE_SAT[WORD_BITS-1:0];
  localparam word_t WORD_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t WORD_ZERO = '0;

  localparam logic MODE_MUL = 1'b0;
  localparam logic MODE_ROT = 1'b1;

  typedef struct packed {
    logic  mode;
    word_t a_w;
    word_t a_x;
    word_t a_y;
    word_t a_z;
    word_t b_w;
    word_t b_x;
    word_t b_y;
    word_t b_z;
  } in_item_t;

  typedef struct packed {
    word_t r_w;
    word_t r_x;
    word_t r_y;
    word_t r_z;
  } out_item_t;

  // Data that rides along a product unit next to the operands.
  typedef struct packed {
    logic  mode;
    quat_t q;
  } qmr_side_t;

  // Hamilton product terms: output component k is the sum over m of
  // +/- l[TERM_L[k][m]] * r[TERM_R[k][m]], negated where TERM_NEG is set.
  localparam logic [1:0] TERM_L [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };
  localparam logic [1:0] TERM_R [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}
  };
  localparam logic TERM_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1}
  };

  // Conjugating the right operand flips every term that uses its vector part.
  function automatic logic term_neg(input logic conj, input int k, input int m);
    return TERM_NEG[k][m] ^ (conj && (TERM_R[k][m] != 2'd0));
  endfunction

  function automatic pair_t signed_term(input prod_t p, input logic neg);
    pair_t e;
    e = {p[PROD_W-1], p};
    return neg ? -e : e;
  endfunction

  // Floor shift by the fraction width, then clamp to the word range.
  function automatic word_t sat_word(input sum_t s);
    sum_t sh;
    logic [SUM_W-WORD_BITS:0] upper;
    sh = s >>> FRAC_BITS;
    upper = sh[SUM_W-1:WORD_BITS-1];
    if ((&upper) || !(|upper)) begin
      return sh[WORD_BITS-1:0];
    end else if (sh[SUM_W-1]) begin
      return WORD_MIN;
    end else begin
      return WORD_MAX;
    end
  endfunction

endpackage

FILE: hw/rtl/qmr_hprod.sv
// Four-stage pipelined Hamilton product with an optional conjugated right operand.
`timescale 1ns / 1ps

module qmr_hprod (
  input  logic              clk,
  input  logic              rst,
  input  logic              conj,
  input  logic              in_valid,
  output logic              in_ready,
  input  qmr_pkg::quat_t    l,
  input  qmr_pkg::quat_t    r,
  input  qmr_pkg::qmr_side_t side_in,
  output logic              out_valid,
  input  logic              out_ready,
  output qmr_pkg::quat_t    q,
  output qmr_pkg::qmr_side_t side_out
);
  import qmr_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  prod_t     p1 [4][4];
  pair_t     pair2 [4][2];
  pair_t     pair_next [4][2];
  sum_t      sum3 [4];
  quat_t     q4;
  qmr_side_t side1, side2, side3, side4;

  // A stage loads when it is empty or the stage after it moves, so bubbles close up.
  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign in_ready  = en1;
  assign out_valid = v4;
  assign q         = q4;
  assign side_out  = side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int n = 0; n < 2; n++) begin
        pair_next[k][n] =
          signed_term(p1[TERM_L[k][2*n]][TERM_R[k][2*n]], term_neg(conj, k, 2*n)) +
          signed_term(p1[TERM_L[k][2*n+1]][TERM_R[k][2*n+1]], term_neg(conj, k, 2*n+1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p1[i][j] <= $signed(l[i]) * $signed(r[j]);
        end
      end
      side1 <= side_in;
    end
    if (en2) begin
      pair2 <= pair_next;
      side2 <= side1;
    end
    if (en3) begin
      for (int k = 0; k < 4; k++) begin
        sum3[k] <= {pair2[k][0][PAIR_W-1], pair2[k][0]} +
                   {pair2[k][1][PAIR_W-1], pair2[k][1]};
      end
      side3 <= side2;
    end
    if (en4) begin
      for (int k = 0; k < 4; k++) begin
        q4[k] <= sat_word(sum3[k]);
      end
      side4 <= side3;
    end
  end

endmodule

FILE: hw/rtl/quaternion_multiply_rotate_top.sv
// Top level of the quaternion unit: Hamilton product or vector rotation.
//
//   channel | signals                       | direction | payload
//   input   | in_valid, in_ready, in_item   | in        | mode, a_w..a_z, b_w..b_z
//   output  | out_valid, out_ready, out_item| out       | r_w, r_x, r_y, r_z
//
// One item enters per cycle while in_ready is high; each result passes through eight
// register stages in two product units of four each (multiply, pair add, final add,
// shift and clamp). Reset empties the pipeline and drops nothing else.
// A stall at the output backs up only as far as the full stages, so empty stages
// keep taking items. In multiply mode the second unit's work is discarded.
`timescale 1ns / 1ps

module quaternion_multiply_rotate_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qmr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output qmr_pkg::out_item_t out_item
);
  import qmr_pkg::*;

  quat_t     a_in, b_in;
  qmr_side_t side_a;
  quat_t     t_q;
  qmr_side_t t_side;
  logic      t_valid, t_ready;
  qmr_side_t side_t;
  quat_t     r_q;
  qmr_side_t r_side;

  assign a_in = {in_item.a_z, in_item.a_y, in_item.a_x, in_item.a_w};
  // Rotation treats the vector as the quaternion (1, v).
  assign b_in = {in_item.b_z, in_item.b_y, in_item.b_x,
                 (in_item.mode == MODE_ROT) ? ONE_Q : in_item.b_w};
  assign side_a = '{mode: in_item.mode, q: a_in};

  qmr_hprod u_first (
    .clk       (clk),
    .rst       (rst),
    .conj      (1'b0),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .l         (a_in),
    .r         (b_in),
    .side_in   (side_a),
    .out_valid (t_valid),
    .out_ready (t_ready),
    .q         (t_q),
    .side_out  (t_side)
  );

  // The second unit forms t * conj(a); the first result rides along for multiply mode.
  assign side_t = '{mode: t_side.mode, q: t_q};

  qmr_hprod u_second (
    .clk       (clk),
    .rst       (rst),
    .conj      (1'b1),
    .in_valid  (t_valid),
    .in_ready  (t_ready),
    .l         (t_q),
    .r         (t_side.q),
    .side_in   (side_t),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .q         (r_q),
    .side_out  (r_side)
  );

  always_comb begin
    if (r_side.mode == MODE_ROT) begin
      out_item = '{r_w: WORD_ZERO, r_x: r_q[1], r_y: r_q[2], r_z: r_q[3]};
    end else begin
      out_item = '{r_w: r_side.q[0], r_x: r_side.q[1], r_y: r_side.q[2],
                   r_z: r_side.q[3]};
    end
  end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the quaternion product and rotation unit.
`timescale 1ns / 1ps

module tb_top;
  import qmr_pkg::*;

  // Products and four-term sums are formed exactly at this width.
  typedef logic signed [2*WORD_BITS+7:0] wide_t;

  localparam int    STALL_LIMIT    = 1000;
  localparam int    RX_HOLD_CYCLES = 80;
  localparam int    DRAIN_CYCLES   = 16;
  localparam word_t Q_ONE          = 32'sd65536;
  localparam word_t COS45          = 32'sd46341;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;

  out_item_t  pending_results[$];
  int         err_count = 0;
  int         n_mul = 0;
  int         n_rot = 0;
  int         n_checked = 0;
  int         idle_cycles = 0;
  bit         tx_jitter = 1'b1;
  bit         rx_jitter = 1'b1;
  bit         rx_hold_req = 1'b0;
  int         rx_hold_left = 0;
  int         rx_gap_left = 0;

  quaternion_multiply_rotate_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor shift by the fraction width, then clamp into the word range.
  function automatic wide_t shift_sat(input wide_t s);
    wide_t sh;
    wide_t hi;
    wide_t lo;
    sh = s >>> FRAC_BITS;
    hi = $signed(WORD_MAX);
    lo = $signed(WORD_MIN);
    if (sh > hi) begin
      return hi;
    end else if (sh < lo) begin
      return lo;
    end
    return sh;
  endfunction

  function automatic void hamilton(input wide_t l0, l1, l2, l3, r0, r1, r2, r3,
                                   output wide_t o0, o1, o2, o3);
    o0 = shift_sat(l0 * r0 - l1 * r1 - l2 * r2 - l3 * r3);
    o1 = shift_sat(l0 * r1 + l1 * r0 + l2 * r3 - l3 * r2);
    o2 = shift_sat(l0 * r2 + l2 * r0 + l3 * r1 - l1 * r3);
    o3 = shift_sat(l0 * r3 + l3 * r0 + l1 * r2 - l2 * r1);
  endfunction

  function automatic out_item_t quat_unit_result(input in_item_t it);
    wide_t a0, a1, a2, a3, b0, b1, b2, b3;
    wide_t t0, t1, t2, t3, r0, r1, r2, r3;
    wide_t one;
    out_item_t res;
    a0 = $signed(it.a_w);
    a1 = $signed(it.a_x);
    a2 = $signed(it.a_y);
    a3 = $signed(it.a_z);
    b0 = $signed(it.b_w);
    b1 = $signed(it.b_x);
    b2 = $signed(it.b_y);
    b3 = $signed(it.b_z);
    if (it.mode == MODE_MUL) begin
      hamilton(a0, a1, a2, a3, b0, b1, b2, b3, r0, r1, r2, r3);
    end else begin
      // The real part of (1,v) is one, clamped if the format cannot hold it.
      one = wide_t'(1) <<< FRAC_BITS;
      if (one > $signed(WORD_MAX)) begin
        one = $signed(WORD_MAX);
      end
      hamilton(a0, a1, a2, a3, one, b1, b2, b3, t0, t1, t2, t3);
      // The conjugate is negated at full width, so the most negative word stays exact.
      hamilton(t0, t1, t2, t3, a0, -a1, -a2, -a3, r0, r1, r2, r3);
      r0 = '0;
    end
    res.r_w = r0[WORD_BITS-1:0];
    res.r_x = r1[WORD_BITS-1:0];
    res.r_y = r2[WORD_BITS-1:0];
    res.r_z = r3[WORD_BITS-1:0];
    return res;
  endfunction

  function automatic in_item_t quat_item(input logic m, input word_t aw, ax, ay, az,
                                         input word_t bw, bx, by, bz);
    in_item_t it;
    it.mode = m;
    it.a_w = aw;
    it.a_x = ax;
    it.a_y = ay;
    it.a_z = az;
    it.b_w = bw;
    it.b_x = bx;
    it.b_y = by;
    it.b_z = bz;
    return it;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return WORD_ZERO;
      3, 4, 5: return word_t'($urandom_range(0, 1 << 18)) - word_t'(1 << 17);
      default: return word_t'($urandom());
    endcase
  endfunction

  // Rotations mostly use quaternion coefficients within [-1, 1] to limit how far the vector grows.
  function automatic word_t rand_coeff();
    if ($urandom_range(0, 4) == 0) begin
      return rand_word();
    end
    return word_t'($urandom_range(0, 2 * 65536)) - Q_ONE;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.mode = 1'($urandom_range(0, 1));
    if (it.mode == MODE_MUL) begin
      it.a_w = rand_word();
      it.a_x = rand_word();
      it.a_y = rand_word();
      it.a_z = rand_word();
    end else begin
      it.a_w = rand_coeff();
      it.a_x = rand_coeff();
      it.a_y = rand_coeff();
      it.a_z = rand_coeff();
    end
    it.b_w = rand_word();
    it.b_x = rand_word();
    it.b_y = rand_word();
    it.b_z = rand_word();
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input in_item_t it);
    if (tx_jitter && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_item = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready = 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      out_ready = 1'b0;
    end else if (rx_jitter && $urandom_range(0, 7) == 0) begin
      rx_gap_left = $urandom_range(0, 11);
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pending_results.push_back(quat_unit_result(in_item));
      if (in_item.mode == MODE_MUL) begin
        n_mul++;
      end else begin
        n_rot++;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    word_t     want_f[4];
    word_t     got_f[4];
    string     names[4];
    if (!rst && out_valid && out_ready) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t tb_top: unexpected result, expected none, got %h", $time, out_item);
      end else begin
        want = pending_results.pop_front();
        names = '{"r_w", "r_x", "r_y", "r_z"};
        want_f = '{want.r_w, want.r_x, want.r_y, want.r_z};
        got_f = '{out_item.r_w, out_item.r_x, out_item.r_y, out_item.r_z};
        for (int i = 0; i < 4; i++) begin
          if (got_f[i] !== want_f[i]) begin
            err_count++;
            $display("%0t tb_top: %s mismatch, expected %0d, got %0d",
                     $time, names[i], want_f[i], got_f[i]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t tb_top: no handshake for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_results.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic test_mul_directed();
    send_item(quat_item(MODE_MUL, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(quat_item(MODE_MUL, Q_ONE, 0, 0, 0, 32'sd98304, -32'sd131072, 32'sd196608,
                        -32'sd16384));
    // i*j = k, j*i = -k, k*k = -1.
    send_item(quat_item(MODE_MUL, 0, Q_ONE, 0, 0, 0, 0, Q_ONE, 0));
    send_item(quat_item(MODE_MUL, 0, 0, Q_ONE, 0, 0, Q_ONE, 0, 0));
    send_item(quat_item(MODE_MUL, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE));
    // Saturation toward both ends.
    send_item(quat_item(MODE_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                        WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    send_item(quat_item(MODE_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                        WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    send_item(quat_item(MODE_MUL, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
                        WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX));
    // Tiny negative products must round toward minus infinity.
    send_item(quat_item(MODE_MUL, -32'sd1, 0, 0, 0, 32'sd1, 32'sd1, 32'sd1, 32'sd1));
    send_item(quat_item(MODE_MUL, 32'sd3, -32'sd7, 32'sd5, -32'sd2, -32'sd5, 32'sd9,
                        -32'sd1, 32'sd4));
    send_item(quat_item(MODE_MUL, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
                        32'sh55555555, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
                        32'shAAAAAAAA));
  endtask

  task automatic test_rot_directed();
    // The real part of b is ignored when rotating.
    send_item(quat_item(MODE_ROT, Q_ONE, 0, 0, 0, WORD_MAX, Q_ONE, 32'sd131072,
                        32'sd196608));
    send_item(quat_item(MODE_ROT, COS45, 0, 0, COS45, WORD_MIN, Q_ONE, 0, 0));
    // Most negative vector component of a, whose conjugate does not fit a word.
    send_item(quat_item(MODE_ROT, 0, WORD_MIN, 0, 0, 0, 32'sd12345, -32'sd777, 32'sd3));
    send_item(quat_item(MODE_ROT, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                        WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    send_item(quat_item(MODE_ROT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                        WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    // A non-unit quaternion scales the vector by its squared norm.
    send_item(quat_item(MODE_ROT, 32'sd131072, 0, 0, 0, 0, Q_ONE, -Q_ONE, 32'sd32768));
    send_item(quat_item(MODE_ROT, 0, 0, 0, 0, 32'sd5, WORD_MAX, WORD_MIN, 32'sd1));
    send_item(quat_item(MODE_ROT, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
                        WORD_MIN, WORD_MIN, WORD_MAX, 0));
    send_item(quat_item(MODE_ROT, 0, Q_ONE, 0, 0, 0, -32'sd1, -32'sd1, 32'sd3));
  endtask

  task automatic test_random_mix();
    repeat (820) send_item(rand_item());
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // pipeline fills and the input side has to stall.
  task automatic test_output_backpressure();
    rx_hold_req = 1'b1;
    tx_jitter = 1'b0;
    repeat (60) send_item(rand_item());
    tx_jitter = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (20) send_item(rand_item());
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) send_item(rand_item());
  endtask

  task automatic test_full_rate();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    repeat (160) send_item(rand_item());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_mul_directed();
    test_rot_directed();
    test_random_mix();
    test_output_backpressure();
    test_drain_pause();
    test_full_rate();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: %0d items in (%0d multiply, %0d rotate), %0d results compared",
             n_mul + n_rot, n_mul, n_rot, n_checked);
    $display("tb_top: covered word extremes, floor rounding, a long output stall, %s",
             "a drained pause and full-rate streaming");
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: %0d mismatches", err_count);
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/qmr_pkg.sv
hw/rtl/qmr_hprod.sv
hw/rtl/quaternion_multiply_rotate_top.sv
verif/tb_top.sv
